### rtl/bt_pkg.sv
package bt_pkg;

   // Defaults for the top-level parameters.
   localparam int KEY_BITS_DEF   = 31;
   localparam int NODE_COUNT_DEF = 32768;

   // Fixed widths of the stream fields.
   localparam int KEY_FIELD_BITS = 31;
   localparam int REQ_DATA_BITS  = 32;
   localparam int RSP_DATA_BITS  = 32;

   // Operation codes carried in req_tuser.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // Controls from the sequencer to the digit shifter.
   typedef struct packed {
      logic load;     // load a new key and clear the result
      logic shift;    // step to the next key bit
      logic res_bit;  // result bit decided in this step
   } shift_ctl_type;

endpackage

### rtl/bt_node_mem.sv
module bt_node_mem
   import bt_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF,
   parameter int PTR_BITS   = $clog2(NODE_COUNT_DEF)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [PTR_BITS-1:0]     wr_addr,
   input  logic [2*PTR_BITS-1:0]   wr_data,
   input  logic [PTR_BITS-1:0]     rd_addr,
   output logic [2*PTR_BITS-1:0]   rd_data
);

   // One word per node: the child on branch one above the child on branch zero.
   logic [2*PTR_BITS-1:0] mem [NODE_COUNT];
   logic [2*PTR_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bt_digit_shift.sv
module bt_digit_shift
   import bt_pkg::*;
#(
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  logic                clock,
   input  shift_ctl_type       ctl,
   input  logic [KEY_BITS-1:0] key_load,
   output logic                key_msb,
   output logic [KEY_BITS-1:0] result
);

   // The key leaves at the top one bit per step; result bits enter at the bottom.
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] res_ff, res_in;

   always_comb begin
      key_in = key_ff;
      res_in = res_ff;
      if (ctl.load) begin
         key_in = key_load;
         res_in = '0;
      end else if (ctl.shift) begin
         key_in = {key_ff[KEY_BITS-2:0], 1'b0};
         res_in = {res_ff[KEY_BITS-2:0], ctl.res_bit};
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      res_ff <= res_in;
   end

   assign key_msb = key_ff[KEY_BITS-1];
   assign result  = res_ff;

endmodule

### rtl/binary_trie_max_xor.sv
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tuser: op; tdata: key
// rsp       out        rsp_tvalid/rsp_tready  tdata: best_xor, store_full
//
// An item runs in steps: one to accept it and start the root read, one per key
// bit to follow a child link through the node memory, and one to hand the word
// to the output register, held while that register is still full. A dropped
// insert skips the walk. The registered read of the node memory sets its pace.
// Reset clears the allocation count and a root flag at once; no clearing pass
// runs, because a node word not yet written is masked to zero by a fresh flag.
// A finished result waits in the output register while the next word is taken.
module binary_trie_max_xor
   import bt_pkg::*;
#(
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [30:0] key, [31] zero
   input  logic                     req_tuser,   // [0] op
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata    // [30:0] best_xor, [31] store_full
);

   localparam int PTR_BITS = $clog2(NODE_COUNT);
   localparam int CNT_BITS = $clog2(KEY_BITS);
   // Key bits that the stream field can actually carry.
   localparam int KEY_USED = (KEY_BITS < KEY_FIELD_BITS) ? KEY_BITS : KEY_FIELD_BITS;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [PTR_BITS-1:0] node_ff, node_in;         // node whose word is being read
   logic [PTR_BITS-1:0] next_free_ff, next_free_in;
   logic                root_written_ff, root_written_in;
   logic                fresh_ff, fresh_in;       // current node holds no links yet
   logic                op_ff, op_in;
   logic                full_ff, full_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [KEY_BITS-1:0]   key_ext;
   logic [KEY_BITS-1:0]   result;
   logic                  key_msb;
   shift_ctl_type         ctl;

   logic                  mem_wr_en;
   logic [2*PTR_BITS-1:0] mem_wr_data;
   logic [PTR_BITS-1:0]   mem_rd_addr;
   logic [2*PTR_BITS-1:0] mem_rd_data;

   logic [2*PTR_BITS-1:0] word;
   logic [PTR_BITS-1:0]   link_same, link_opp, new_node;
   logic                  accept, store_full_now;
   logic [KEY_FIELD_BITS-1:0] best_xor;

   // The key field is zero-extended (or cut) to the trie's key width.
   always_comb begin
      key_ext = '0;
      for (int i = 0; i < KEY_USED; i++) begin
         key_ext[i] = req_tdata[i];
      end
   end

   always_comb begin
      best_xor = '0;
      for (int i = 0; i < KEY_USED; i++) begin
         best_xor[i] = result[i];
      end
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Fewer than KEY_BITS free nodes left means the insert is dropped.
   assign store_full_now = (int'(next_free_ff) + KEY_BITS) > (NODE_COUNT - 1);

   // A node that has never been written reads as having no children.
   assign word      = fresh_ff ? '0 : mem_rd_data;
   assign link_same = key_msb ? word[2*PTR_BITS-1:PTR_BITS] : word[PTR_BITS-1:0];
   assign link_opp  = key_msb ? word[PTR_BITS-1:0] : word[2*PTR_BITS-1:PTR_BITS];
   assign new_node  = next_free_ff + PTR_BITS'(1);

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      node_in         = node_ff;
      next_free_in    = next_free_ff;
      root_written_in = root_written_ff;
      fresh_in        = fresh_ff;
      op_in           = op_ff;
      full_in         = full_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      ctl             = '0;
      mem_wr_en       = 1'b0;
      mem_wr_data     = word;
      mem_rd_addr     = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // The root word is read in the accept cycle.
            if (accept) begin
               ctl.load = 1'b1;
               op_in    = req_tuser;
               cnt_in   = CNT_BITS'(KEY_BITS - 1);
               node_in  = '0;
               fresh_in = !root_written_ff;
               if (req_tuser == OP_INSERT && store_full_now) begin
                  full_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  full_in  = 1'b0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            ctl.shift = 1'b1;
            if (op_ff == OP_QUERY) begin
               if (link_opp != '0) begin
                  ctl.res_bit = 1'b1;
                  node_in     = link_opp;
               end else begin
                  node_in     = link_same;
               end
               fresh_in = (node_in == '0) && !root_written_ff;
            end else if (link_same == '0) begin
               // Missing link: allocate the next node and write the whole word.
               next_free_in = new_node;
               node_in      = new_node;
               fresh_in     = 1'b1;
               mem_wr_en    = 1'b1;
               if (key_msb) begin
                  mem_wr_data = {new_node, word[PTR_BITS-1:0]};
               end else begin
                  mem_wr_data = {word[2*PTR_BITS-1:PTR_BITS], new_node};
               end
               if (node_ff == '0) begin
                  root_written_in = 1'b1;
               end
            end else begin
               node_in  = link_same;
               fresh_in = 1'b0;
            end
            mem_rd_addr = node_in;
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {full_ff, best_xor};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         next_free_ff    <= '0;
         root_written_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         next_free_ff    <= next_free_in;
         root_written_ff <= root_written_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      node_ff     <= node_in;
      fresh_ff    <= fresh_in;
      op_ff       <= op_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   bt_digit_shift #(
      .KEY_BITS (KEY_BITS)
   ) u_shift (
      .clock    (clock),
      .ctl      (ctl),
      .key_load (key_ext),
      .key_msb  (key_msb),
      .result   (result)
   );

   bt_node_mem #(
      .NODE_COUNT (NODE_COUNT),
      .PTR_BITS   (PTR_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (node_ff),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

### tb/binary_trie_max_xor_tb.sv
`timescale 1ns / 100ps

module binary_trie_max_xor_tb;
   import bt_pkg::*;

   // Quiet cycles allowed before the run is declared hung. The slowest gap
   // between two handshakes is the long receiver hold plus one walk of the
   // trie and the largest idle on both sides, so this leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 4000;

   // The receiver stops taking words for this long once, after HOLD_AT words.
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 600;

   // Number of items in the random part of the stimulus.
   localparam int RANDOM_ITEMS = 1650;

   // Wait after the drain, sized for two walks of the trie.
   localparam int SETTLE_CYCLES = 2 * (KEY_BITS_DEF + 2);

   typedef logic [KEY_FIELD_BITS-1:0] trie_key_type;

   typedef struct packed {
      logic         op;
      trie_key_type key;
   } trie_cmd_type;

   typedef struct packed {
      logic         store_full;
      trie_key_type best_xor;
   } trie_rsp_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;   // [30:0] key, [31] zero
   logic                     req_tuser  = OP_INSERT;   // [0] op
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // [30:0] best_xor, [31] store_full

   binary_trie_max_xor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Reset is held at the start and never again.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Trie predictor. Node 0 is the root and is never anyone's child, so a
   // zero link means the branch does not exist.
   // ------------------------------------------------------------------
   int trie_link [NODE_COUNT_DEF][2];
   int trie_nodes_used = 0;

   function automatic trie_rsp_type trie_apply(input logic op, input trie_key_type key);
      trie_rsp_type r;
      int           node;
      int           branch;
      r    = '0;
      node = 0;
      if (op == OP_INSERT) begin
         // An insert needs room for a whole path up front, even when the key
         // is already stored and would not allocate anything.
         if (NODE_COUNT_DEF - 1 - trie_nodes_used < KEY_BITS_DEF) begin
            r.store_full = 1'b1;
         end else begin
            for (int i = KEY_BITS_DEF - 1; i >= 0; i--) begin
               branch = int'(key[i]);
               if (trie_link[node][branch] == 0) begin
                  trie_nodes_used++;
                  trie_link[node][branch] = trie_nodes_used;
               end
               node = trie_link[node][branch];
            end
         end
      end else begin
         // Greedy walk: prefer the branch that disagrees with the key bit.
         for (int i = KEY_BITS_DEF - 1; i >= 0; i--) begin
            branch = int'(!key[i]);
            if (trie_link[node][branch] != 0) begin
               r.best_xor[i] = 1'b1;
               node = trie_link[node][branch];
            end else begin
               node = trie_link[node][int'(key[i])];
            end
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Queues shared between the stimulus, the driver and the monitor.
   // ------------------------------------------------------------------
   trie_cmd_type cmd_backlog [$];   // items not yet offered on req
   trie_rsp_type rsp_awaited [$];   // predicted words, oldest first
   trie_key_type stored_keys [$];   // keys sent as inserts, for reuse
   int           mismatch_count = 0;

   task automatic queue_cmd(input logic op, input trie_key_type key);
      cmd_backlog.push_back('{op: op, key: key});
      if (op == OP_INSERT) stored_keys.push_back(key);
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Driver. It predicts each item at the edge where it is accepted, then
   // waits a drawn number of cycles before offering the next one. Now and
   // then it flips into a burst mode where it offers back to back.
   // ------------------------------------------------------------------
   trie_cmd_type drv_cmd;
   trie_rsp_type drv_pred;
   logic         drv_offering = 1'b0;
   logic         drv_burst    = 1'b0;
   int           drv_gap      = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= OP_INSERT;
         drv_gap    = 0;
      end else begin
         drv_offering = req_tvalid;
         if (req_tvalid && req_tready) begin
            drv_pred = trie_apply(req_tuser, req_tdata[KEY_FIELD_BITS-1:0]);
            rsp_awaited.push_back(drv_pred);
            drv_offering = 1'b0;
            if ($urandom_range(0, 31) == 0) drv_burst = !drv_burst;
            drv_gap = drv_burst ? 0 : $urandom_range(0, 9);
         end
         // A word still on offer keeps its valid and data untouched.
         if (!drv_offering) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_tvalid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               drv_cmd    = cmd_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_BITS'(drv_cmd.key);
               req_tuser  <= drv_cmd.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor. Each word taken is checked against the oldest prediction.
   // After every word the receiver idles a drawn number of cycles, or none in
   // its burst mode, and once it holds off for a long stretch so that the block
   // backs up and stops taking items on req.
   // ------------------------------------------------------------------
   trie_rsp_type mon_want;
   logic         mon_burst = 1'b0;
   int           mon_wait  = 0;
   int           mon_hold  = 0;
   int           mon_seen  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_awaited.size() == 0) begin
               report_mismatch($sformatf("word %h with nothing pending", rsp_tdata));
            end else begin
               mon_want = rsp_awaited.pop_front();
               if (rsp_tdata[KEY_FIELD_BITS-1:0] !== mon_want.best_xor)
                  report_mismatch($sformatf("best_xor %h, predicted %h",
                                            rsp_tdata[KEY_FIELD_BITS-1:0],
                                            mon_want.best_xor));
               if (rsp_tdata[KEY_FIELD_BITS] !== mon_want.store_full)
                  report_mismatch($sformatf("store_full %b, predicted %b",
                                            rsp_tdata[KEY_FIELD_BITS],
                                            mon_want.store_full));
            end
            mon_seen++;
            if (mon_seen == HOLD_AT) mon_hold = HOLD_CYCLES;
            if ($urandom_range(0, 31) == 0) mon_burst = !mon_burst;
            mon_wait = mon_burst ? 0 : $urandom_range(0, 9);
         end
         if (mon_hold > 0) begin
            mon_hold--;
            rsp_tready <= 1'b0;
         end else if (mon_wait > 0) begin
            mon_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: the run is hung when neither side has moved a word for too
   // long.
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("binary_trie_max_xor_tb: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------
   initial begin
      int           random_sent;
      int           pick;
      trie_key_type rand_key;
      trie_key_type base_key;
      random_sent = 0;

      // Queries on the empty store must come back as zero.
      queue_cmd(OP_QUERY,  '0);
      queue_cmd(OP_QUERY,  '1);
      // A single stored key of all zeros.
      queue_cmd(OP_INSERT, '0);
      queue_cmd(OP_QUERY,  '0);
      queue_cmd(OP_QUERY,  '1);
      // A duplicate insert allocates nothing and is not refused.
      queue_cmd(OP_INSERT, '0);
      queue_cmd(OP_INSERT, '1);
      queue_cmd(OP_QUERY,  trie_key_type'(31'h2AAA_AAAA));
      queue_cmd(OP_QUERY,  trie_key_type'(31'h5555_5555));
      queue_cmd(OP_INSERT, trie_key_type'(31'h4000_0000));
      queue_cmd(OP_INSERT, trie_key_type'(31'h0000_0001));
      queue_cmd(OP_INSERT, '1);
      queue_cmd(OP_QUERY,  trie_key_type'(31'h4000_0000));
      queue_cmd(OP_QUERY,  trie_key_type'(31'h0000_0001));
      queue_cmd(OP_INSERT, trie_key_type'(31'h2AAA_AAAA));
      queue_cmd(OP_INSERT, trie_key_type'(31'h5555_5555));
      queue_cmd(OP_QUERY,  trie_key_type'(31'h1234_5678));
      queue_cmd(OP_QUERY,  trie_key_type'(31'h7FFF_FFFE));
      queue_cmd(OP_QUERY,  trie_key_type'(31'h3FFF_FFFF));

      // Random part. Mostly inserts so that the trie grows deep and wide.
      // Queries lean on stored keys, their complements and near neighbors so
      // that the greedy walk takes both branches deep into the trie.
      while (random_sent < RANDOM_ITEMS) begin
         while (cmd_backlog.size() >= 4) @(posedge clock);
         pick     = $urandom_range(0, 99);
         rand_key = trie_key_type'($urandom());
         if ($urandom_range(0, 99) < 80) begin
            if (pick < 15 && stored_keys.size() > 0)
               rand_key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else if (pick < 22)
               rand_key = trie_key_type'($urandom_range(0, 15));
            else if (pick < 29)
               rand_key = ~trie_key_type'($urandom_range(0, 15));
            queue_cmd(OP_INSERT, rand_key);
         end else begin
            if (stored_keys.size() > 0) begin
               base_key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
               if (pick < 30)
                  rand_key = base_key;
               else if (pick < 45)
                  rand_key = ~base_key;
               else if (pick < 55)
                  rand_key = base_key ^ (trie_key_type'(1) <<
                                         $urandom_range(0, KEY_FIELD_BITS - 1));
            end
            queue_cmd(OP_QUERY, rand_key);
         end
         random_sent++;
      end

      // Drain: everything offered, everything predicted has come back.
      while (cmd_backlog.size() > 0 || req_tvalid || rsp_awaited.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (rsp_awaited.size() != 0)
         report_mismatch($sformatf("%0d predicted words never arrived", rsp_awaited.size()));

      if (mismatch_count == 0) begin
         $display("binary_trie_max_xor_tb: PASS");
      end else begin
         $display("binary_trie_max_xor_tb: FAIL");
      end
      $finish;
   end

endmodule

### binary_trie_max_xor.f
rtl/bt_pkg.sv
rtl/bt_node_mem.sv
rtl/bt_digit_shift.sv
rtl/binary_trie_max_xor.sv
tb/binary_trie_max_xor_tb.sv
